/* rtl/vgtp_pkg.sv */
package vgtp_pkg;

	// Longest text that is still valid, in bytes.
	localparam int MAX_TEXT_BYTES = 4096;

	// The byte counter saturates at one past the maximum, so it must hold that value.
	localparam int CNT_W = $clog2(MAX_TEXT_BYTES + 2);
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TEXT_BYTES);

	// Geometry dimensions.
	localparam int DIM_W = 15;
	localparam int SUM_W = DIM_W + 3;
	localparam logic [SUM_W-1:0] DIM_LIMIT = SUM_W'(16384);

	// Length of the video= prefix.
	localparam logic [2:0] PREFIX_LEN = 3'd6;

	// Result status codes.
	localparam logic [1:0] STATUS_ABSENT = 2'd0;
	localparam logic [1:0] STATUS_FOUND = 2'd1;
	localparam logic [1:0] STATUS_INVALID = 2'd2;

	// Position within the current token.
	typedef enum logic [2:0] {
		PH_START,
		PH_PREFIX,
		PH_OTHER,
		PH_W_FIRST,
		PH_W_DIGITS,
		PH_H_FIRST,
		PH_H_DIGITS
	} phase_t;

	// One result item as it passes from the parser core to the output register.
	typedef struct packed {
		logic [1:0]       status;
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} vgtp_result_t;

	// Expected byte of the video= prefix at a given position.
	function automatic logic [7:0] key_byte(input logic [2:0] idx);
		logic [7:0] b;
		case (idx)
			3'd0: b = 8'h76;
			3'd1: b = 8'h69;
			3'd2: b = 8'h64;
			3'd3: b = 8'h65;
			3'd4: b = 8'h6f;
			3'd5: b = 8'h3d;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

/* rtl/vgtp_core.sv */
module vgtp_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            text_byte,
	input  logic                  last_byte,
	output vgtp_pkg::vgtp_result_t result
);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] BYTE_MIN = 8'd33;
	localparam logic [7:0] BYTE_MAX = 8'd126;

	logic [vgtp_pkg::CNT_W-1:0] bytes_seen_q, cnt_n;
	vgtp_pkg::phase_t           phase_q, phase_n;
	logic [2:0]                 prefix_q, prefix_n;
	logic [vgtp_pkg::DIM_W-1:0] width_q, width_n;
	logic [vgtp_pkg::DIM_W-1:0] height_q, height_n;
	logic                       found_q, found_n;
	logic                       invalid_q, invalid_n;
	logic                       is_digit, is_nonzero;
	logic [vgtp_pkg::SUM_W-1:0] acc_ext, acc_sum;

	// Closing a token: bit 1 marks the text invalid, bit 0 marks a token found.
	function automatic logic [1:0] close_token(input vgtp_pkg::phase_t ph);
		logic [1:0] r;
		case (ph)
			vgtp_pkg::PH_W_FIRST,
			vgtp_pkg::PH_W_DIGITS,
			vgtp_pkg::PH_H_FIRST:  r = 2'b10;
			vgtp_pkg::PH_H_DIGITS: r = 2'b01;
			default:               r = 2'b00;
		endcase
		return r;
	endfunction

	assign is_digit   = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
	assign is_nonzero = (text_byte >= CH_ONE) && (text_byte <= CH_NINE);

	// Next value of whichever dimension is being gathered, with this byte appended as a decimal digit.
	always_comb begin
		if (phase_q == vgtp_pkg::PH_H_DIGITS) begin
			acc_ext = {3'b000, height_q};
		end else begin
			acc_ext = {3'b000, width_q};
		end
		acc_sum = (acc_ext << 3) + (acc_ext << 1) + {{(vgtp_pkg::SUM_W-4){1'b0}}, text_byte[3:0]};
	end

	// Next state for one byte, before the return to reset after the last byte.
	always_comb begin
		logic [1:0] cl;
		cnt_n     = bytes_seen_q;
		phase_n   = phase_q;
		prefix_n  = prefix_q;
		width_n   = width_q;
		height_n  = height_q;
		found_n   = found_q;
		invalid_n = invalid_q;
		cl        = 2'b00;

		if (bytes_seen_q <= vgtp_pkg::MAX_CNT) begin
			cnt_n = bytes_seen_q + 1'b1;
		end
		if (cnt_n > vgtp_pkg::MAX_CNT) begin
			invalid_n = 1'b1;
		end

		if (!invalid_n) begin
			if (text_byte == CH_SPACE) begin
				cl        = close_token(phase_q);
				invalid_n = invalid_n | cl[1];
				found_n   = found_n | cl[0];
				phase_n   = vgtp_pkg::PH_START;
				prefix_n  = 3'd0;
			end else if ((text_byte < BYTE_MIN) || (text_byte > BYTE_MAX)) begin
				invalid_n = 1'b1;
			end else begin
				case (phase_q)
					vgtp_pkg::PH_START,
					vgtp_pkg::PH_PREFIX: begin
						if ((prefix_q < vgtp_pkg::PREFIX_LEN) &&
						    (text_byte == vgtp_pkg::key_byte(prefix_q))) begin
							prefix_n = prefix_q + 3'd1;
							phase_n  = vgtp_pkg::PH_PREFIX;
							if (prefix_n == vgtp_pkg::PREFIX_LEN) begin
								if (found_q) begin
									invalid_n = 1'b1;
								end
								phase_n  = vgtp_pkg::PH_W_FIRST;
								width_n  = '0;
								height_n = '0;
							end
						end else begin
							phase_n = vgtp_pkg::PH_OTHER;
						end
					end
					vgtp_pkg::PH_W_FIRST: begin
						if (is_nonzero) begin
							width_n = {{(vgtp_pkg::DIM_W-4){1'b0}}, text_byte[3:0]};
							phase_n = vgtp_pkg::PH_W_DIGITS;
						end else begin
							invalid_n = 1'b1;
						end
					end
					vgtp_pkg::PH_W_DIGITS: begin
						if (is_digit) begin
							if (acc_sum > vgtp_pkg::DIM_LIMIT) begin
								invalid_n = 1'b1;
							end else begin
								width_n = acc_sum[vgtp_pkg::DIM_W-1:0];
							end
						end else if (text_byte == CH_X) begin
							phase_n = vgtp_pkg::PH_H_FIRST;
						end else begin
							invalid_n = 1'b1;
						end
					end
					vgtp_pkg::PH_H_FIRST: begin
						if (is_nonzero) begin
							height_n = {{(vgtp_pkg::DIM_W-4){1'b0}}, text_byte[3:0]};
							phase_n  = vgtp_pkg::PH_H_DIGITS;
						end else begin
							invalid_n = 1'b1;
						end
					end
					vgtp_pkg::PH_H_DIGITS: begin
						if (is_digit && (acc_sum <= vgtp_pkg::DIM_LIMIT)) begin
							height_n = acc_sum[vgtp_pkg::DIM_W-1:0];
						end else begin
							invalid_n = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end

		// The end of the text also closes the token in progress.
		if (last_byte && !invalid_n) begin
			cl        = close_token(phase_n);
			invalid_n = invalid_n | cl[1];
			found_n   = found_n | cl[0];
		end
	end

	// Result item formed from the state after this byte.
	always_comb begin
		if (invalid_n) begin
			result.status = vgtp_pkg::STATUS_INVALID;
			result.width  = '0;
			result.height = '0;
		end else if (found_n) begin
			result.status = vgtp_pkg::STATUS_FOUND;
			result.width  = width_n;
			result.height = height_n;
		end else begin
			result.status = vgtp_pkg::STATUS_ABSENT;
			result.width  = '0;
			result.height = '0;
		end
	end

	// Parser state; the last byte of a text returns it to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			phase_q      <= vgtp_pkg::PH_START;
			prefix_q     <= 3'd0;
			width_q      <= '0;
			height_q     <= '0;
			found_q      <= 1'b0;
			invalid_q    <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				bytes_seen_q <= '0;
				phase_q      <= vgtp_pkg::PH_START;
				prefix_q     <= 3'd0;
				width_q      <= '0;
				height_q     <= '0;
				found_q      <= 1'b0;
				invalid_q    <= 1'b0;
			end else begin
				bytes_seen_q <= cnt_n;
				phase_q      <= phase_n;
				prefix_q     <= prefix_n;
				width_q      <= width_n;
				height_q     <= height_n;
				found_q      <= found_n;
				invalid_q    <= invalid_n;
			end
		end
	end

endmodule

/* rtl/vgtp_out_reg.sv */
module vgtp_out_reg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load,
	input  vgtp_pkg::vgtp_result_t     result,
	input  logic                       out_stall,
	output logic                       out_ready,
	output logic                       out_valid,
	output logic [1:0]                 parse_status,
	output logic [vgtp_pkg::DIM_W-1:0] width_pixels,
	output logic [vgtp_pkg::DIM_W-1:0] height_pixels
);

	logic                   valid_q;
	vgtp_pkg::vgtp_result_t result_q;

	// The register can take a new item when it is empty or its item leaves now.
	assign out_ready = !valid_q || !out_stall;

	// Valid flag of the held result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// Result payload, held while stalled.
	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result;
		end
	end

	assign out_valid     = valid_q;
	assign parse_status  = result_q.status;
	assign width_pixels  = result_q.width;
	assign height_pixels = result_q.height;

endmodule

/* rtl/video_geometry_token_parser_top.sv */
// The result is loaded into the output register as the last byte enters the parser.
// One byte per cycle unless stalled; the input register is freed as its byte enters the parser.
// A last byte waits in the input register only while an earlier result is held by out_stall.
// Reset (arst_n low, asynchronous) empties both registers and returns the parser to the
// start of a text; each last byte also returns the parser to that state.
module video_geometry_token_parser_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [7:0]                 text_byte,
	input  logic                       last_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 parse_status,
	output logic [vgtp_pkg::DIM_W-1:0] width_pixels,
	output logic [vgtp_pkg::DIM_W-1:0] height_pixels
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   last_s1;
	logic                   step;
	logic                   out_ready;
	vgtp_pkg::vgtp_result_t result;

	// A byte enters the parser unless it is a last byte and the output holds a stalled result.
	assign step     = valid_s1 && (!last_s1 || out_ready);
	assign in_stall = valid_s1 && !step;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= text_byte;
			last_s1 <= last_byte;
		end
	end

	vgtp_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.text_byte (byte_s1),
		.last_byte (last_s1),
		.result    (result)
	);

	vgtp_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (step && last_s1),
		.result        (result),
		.out_stall     (out_stall),
		.out_ready     (out_ready),
		.out_valid     (out_valid),
		.parse_status  (parse_status),
		.width_pixels  (width_pixels),
		.height_pixels (height_pixels)
	);

endmodule

/* rtl/vgtp_checker.sv */
module vgtp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [1:0]                 parse_status,
	input logic [vgtp_pkg::DIM_W-1:0] width_pixels,
	input logic [vgtp_pkg::DIM_W-1:0] height_pixels
);

	// A stalled result item stays offered and unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(parse_status) &&
		$stable(width_pixels) && $stable(height_pixels))
	else $error("stalled result item changed");

	// Only the three defined status codes are ever reported.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (parse_status == vgtp_pkg::STATUS_ABSENT) ||
		(parse_status == vgtp_pkg::STATUS_FOUND) ||
		(parse_status == vgtp_pkg::STATUS_INVALID))
	else $error("undefined parse status");

	// Geometry is zero unless a token was found.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (parse_status != vgtp_pkg::STATUS_FOUND) |->
		(width_pixels == '0) && (height_pixels == '0))
	else $error("geometry reported without a token");

	// A found token has both dimensions between one and the limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (parse_status == vgtp_pkg::STATUS_FOUND) |->
		(width_pixels != '0) && (height_pixels != '0) &&
		(width_pixels <= 15'd16384) && (height_pixels <= 15'd16384))
	else $error("found geometry out of range");

endmodule

bind video_geometry_token_parser_top vgtp_checker u_vgtp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.parse_status  (parse_status),
	.width_pixels  (width_pixels),
	.height_pixels (height_pixels)
);
